@@ src/wrpe_pkg.sv @@
// ----------------------------------------------------------------------------
// wrpe_pkg
// Shared constants and types of the window RMS / phasor estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpe_pkg;

	localparam int DEF_WINDOW_SIZE = 4;
	localparam int SAMPLE_W        = 10;
	localparam int RMS_W           = 16;
	localparam int PH_W            = 18;
	localparam int COEF_W          = 18;
	localparam int ROOT_W          = 16;

	// finishing phase: a square and a compare step per root bit
	localparam int FIN_CYCLES      = 2 * ROOT_W;
	localparam int FIN_W           = $clog2(FIN_CYCLES);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;

	localparam int PH_MAX = 131071;
	localparam int PH_MIN_MAG = 131072;

	// head of the sample queue as seen by the back end
	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
	} q_head_t;

	// back-end status
	typedef struct packed {
		logic idle;
		logic hold;
	} bk_stat_t;

endpackage : wrpe_pkg

`default_nettype wire

@@ src/wrpe_front.sv @@
// ----------------------------------------------------------------------------
// wrpe_front
// Input side: queues samples in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpe_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [wrpe_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         pop,
	output wrpe_pkg::q_head_t                 head
);
	import wrpe_pkg::*;

	logic [1:0]          cnt_q;
	logic [SAMPLE_W-1:0] slot0_q;
	logic [SAMPLE_W-1:0] slot1_q;
	logic                push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;

	assign head.valid  = (cnt_q != 2'd0);
	assign head.sample = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) slot0_q <= sample;
				else               slot1_q <= sample;
			end
			2'b01: begin
				slot0_q <= slot1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					slot0_q <= sample;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= sample;
				end
			end
			default: begin
				slot0_q <= slot0_q;
			end
		endcase
	end

endmodule : wrpe_front

`default_nettype wire

@@ src/wrpe_cdiv.sv @@
// ----------------------------------------------------------------------------
// wrpe_cdiv
// Division by a fixed divisor through a constant reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpe_cdiv #(
	parameter int DIVISOR = 4,
	parameter int W       = 26
) (
	input  wire logic         clk,
	input  wire logic         load,
	input  wire logic         step,
	input  wire logic [W-1:0] dividend,
	output logic      [W-1:0] quotient
);
	// exact floor for any W-bit dividend: error term stays below 2^SH
	localparam int SH = W + $clog2(DIVISOR);
	localparam int MW = W + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);

	logic [W-1:0]    dvd_q;
	logic [W+MW-1:0] prod_q;

	assign quotient = W'(prod_q >> SH);

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
		end else if (step) begin
			prod_q <= dvd_q * MW'(RECIP);
		end
	end

endmodule : wrpe_cdiv

`default_nettype wire

@@ src/wrpe_back.sv @@
// ----------------------------------------------------------------------------
// wrpe_back
// Back end: window store, walk with multiply-accumulate, root search,
// rounding dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpe_back #(
	parameter int WINDOW_SIZE = wrpe_pkg::DEF_WINDOW_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wrpe_pkg::q_head_t             head,
	output logic                               pop,
	output wrpe_pkg::bk_stat_t                 stat,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic        [wrpe_pkg::RMS_W-1:0]  rms_value,
	output logic signed [wrpe_pkg::PH_W-1:0]   phasor_real,
	output logic signed [wrpe_pkg::PH_W-1:0]   phasor_imag
);
	import wrpe_pkg::*;

	localparam int AW     = $clog2(WINDOW_SIZE);
	localparam int CW     = $clog2(WINDOW_SIZE + 2) + 1;
	localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
	localparam int ACC_W  = PROD_W + AW;
	localparam int SQ1_W  = 2 * SAMPLE_W;
	localparam int SQ_W   = SQ1_W + AW;
	localparam int A_W    = SQ_W + 12;
	localparam int CMP_W  = A_W + 1;
	localparam int DIV_W  = ACC_W - 8;
	localparam int DW     = DIV_W + 1;
	localparam int BP_W   = $clog2(ROOT_W);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WALK = 5'b00010,
		ST_PREP = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_HOLD = 5'b10000
	} st_t;

	// ---- trig coefficients, worked out at elaboration ----
	function automatic longint unsigned sub0(longint unsigned a, longint unsigned b);
		return (a > b) ? (a - b) : 64'd0;
	endfunction

	function automatic longint unsigned hdiv(longint unsigned p, int k, bit is_sin);
		longint unsigned r;
		r = 64'd0;
		if (is_sin) begin
			case (k)
				0:       r = p / 156;
				1:       r = p / 110;
				2:       r = p / 72;
				3:       r = p / 42;
				4:       r = p / 20;
				default: r = p / 6;
			endcase
		end else begin
			case (k)
				0:       r = p / 182;
				1:       r = p / 132;
				2:       r = p / 90;
				3:       r = p / 56;
				4:       r = p / 30;
				default: r = p / 12;
			endcase
		end
		return r;
	endfunction

	// want_im selects the imaginary coefficient (minus sine)
	function automatic logic signed [COEF_W-1:0] coef_q16(int idx, bit want_im);
		longint unsigned m, q, r, x, x2, t;
		longint signed   c, s, cv, sv;
		m = 64'd4 * longint'(idx);
		q = (m / WINDOW_SIZE) & 64'd3;
		r = m % WINDOW_SIZE;
		x = HALF_PI_Q30 * r / WINDOW_SIZE;
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		for (int k = 0; k < 6; k++) t = sub0(ONE_Q30, hdiv((x2 * t) >> 30, k, 1'b1));
		s = longint'((((x * t) >> 30) + 64'd8192) >> 14);
		t = ONE_Q30;
		for (int k = 0; k < 6; k++) t = sub0(ONE_Q30, hdiv((x2 * t) >> 30, k, 1'b0));
		c = longint'((sub0(ONE_Q30, ((x2 * t) >> 30) / 2) + 64'd8192) >> 14);
		case (q)
			64'd0:   begin cv = c;  sv = s;  end
			64'd1:   begin cv = -s; sv = c;  end
			64'd2:   begin cv = -c; sv = -s; end
			default: begin cv = s;  sv = -c; end
		endcase
		return want_im ? COEF_W'(-sv) : COEF_W'(cv);
	endfunction

	logic signed [COEF_W-1:0] re_tab [WINDOW_SIZE];
	logic signed [COEF_W-1:0] im_tab [WINDOW_SIZE];

	for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_tab
		localparam logic signed [COEF_W-1:0] CRE = coef_q16(g, 1'b0);
		localparam logic signed [COEF_W-1:0] CIM = coef_q16(g, 1'b1);
		assign re_tab[g] = CRE;
		assign im_tab[g] = CIM;
	end

	// ---- control ----
	st_t             st_q;
	logic [CW-1:0]   cnt_q;
	logic [FIN_W-1:0] fin_q;
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [WINDOW_SIZE-1:0] vld_q;
	logic            v_s1, v_s2;
	logic            o_valid_q;

	logic [SAMPLE_W-1:0] win_mem [WINDOW_SIZE];
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic [AW-1:0]       idx_s1;
	logic [SAMPLE_W-1:0] smp_s1;

	logic signed [PROD_W-1:0] pre_s2, pim_s2;
	logic [SQ1_W-1:0]         sq_s2;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic [SQ_W-1:0]          sumsq_q;

	logic [A_W-1:0]    a_q;
	logic [ROOT_W-1:0] root_q;
	logic [2*ROOT_W-1:0] rsq_q;
	logic [ROOT_W-1:0] trial;
	logic [BP_W-1:0]   bitpos;
	logic              neg_re_q, neg_im_q;

	logic [ACC_W-1:0]  mag_re, mag_im;
	logic [DIV_W-1:0]  din_re, din_im, quo_re, quo_im;
	logic              issue, wr_en, div_load, div_step, out_load;
	logic [PH_W-1:0]   res_re, res_im;

	function automatic logic [PH_W-1:0] sat_ph(logic [DIV_W-1:0] q, logic neg);
		logic [DW-1:0] qe;
		qe = DW'(q);
		if (neg) begin
			if (qe > DW'(PH_MIN_MAG)) return PH_W'(-PH_MIN_MAG);
			return PH_W'(-qe);
		end
		if (qe > DW'(PH_MAX)) return PH_W'(PH_MAX);
		return PH_W'(qe);
	endfunction

	function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
		return (p == AW'(WINDOW_SIZE - 1)) ? '0 : p + AW'(1);
	endfunction

	assign pop      = (st_q == ST_IDLE) && head.valid;
	assign wr_en    = pop;
	assign issue    = (st_q == ST_WALK) && (cnt_q < CW'(WINDOW_SIZE));
	assign smp_s1   = rd_vld_s1 ? rd_data_s1 : '0;
	assign div_load = (st_q == ST_PREP);
	assign div_step = (st_q == ST_FIN) && (fin_q < FIN_W'(DIV_W));
	assign out_load = (st_q == ST_HOLD) && (!o_valid_q || !out_stall);

	assign stat.idle = (st_q == ST_IDLE);
	assign stat.hold = (st_q == ST_HOLD);

	assign mag_re = acc_re_q[ACC_W-1] ? ACC_W'(-acc_re_q) : ACC_W'(acc_re_q);
	assign mag_im = acc_im_q[ACC_W-1] ? ACC_W'(-acc_im_q) : ACC_W'(acc_im_q);
	assign din_re = DIV_W'((mag_re + ACC_W'(WINDOW_SIZE * 256)) >> 9);
	assign din_im = DIV_W'((mag_im + ACC_W'(WINDOW_SIZE * 256)) >> 9);

	assign bitpos = BP_W'(ROOT_W - 1) - fin_q[FIN_W-1:1];
	assign trial  = root_q | (ROOT_W'(1) << bitpos);

	assign res_re = sat_ph(quo_re, neg_re_q);
	assign res_im = sat_ph(quo_im, neg_im_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			fin_q     <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			vld_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rd_vld_s1 <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			v_s1      <= issue;
			v_s2      <= v_s1;
			rd_vld_s1 <= vld_q[rp_q];
			if (out_load)       o_valid_q <= 1'b1;
			else if (!out_stall) o_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (head.valid) begin
						vld_q[wp_q] <= 1'b1;
						wp_q  <= wrap_inc(wp_q);
						rp_q  <= wrap_inc(wp_q);
						cnt_q <= '0;
						st_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + CW'(1);
					if (issue) rp_q <= wrap_inc(rp_q);
					if (cnt_q == CW'(WINDOW_SIZE + 1)) st_q <= ST_PREP;
				end
				ST_PREP: begin
					fin_q <= '0;
					st_q  <= ST_FIN;
				end
				ST_FIN: begin
					fin_q <= fin_q + FIN_W'(1);
					if (fin_q == FIN_W'(FIN_CYCLES - 1)) st_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// window store and datapath
	always_ff @(posedge clk) begin
		if (wr_en) win_mem[wp_q] <= head.sample;
		rd_data_s1 <= win_mem[rp_q];
		idx_s1     <= cnt_q[AW-1:0];

		pre_s2 <= PROD_W'($signed({1'b0, smp_s1}) * re_tab[idx_s1]);
		pim_s2 <= PROD_W'($signed({1'b0, smp_s1}) * im_tab[idx_s1]);
		sq_s2  <= smp_s1 * smp_s1;

		if (pop) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			sumsq_q  <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(pre_s2);
			acc_im_q <= acc_im_q + ACC_W'(pim_s2);
			sumsq_q  <= sumsq_q + SQ_W'(sq_s2);
		end

		if (st_q == ST_PREP) begin
			a_q      <= {sumsq_q, 12'b0};
			root_q   <= '0;
			neg_re_q <= acc_re_q[ACC_W-1];
			neg_im_q <= acc_im_q[ACC_W-1];
		end else if (st_q == ST_FIN) begin
			if (!fin_q[0]) begin
				rsq_q <= trial * trial;
			end else if (CMP_W'(rsq_q) * CMP_W'(WINDOW_SIZE) <= CMP_W'(a_q)) begin
				root_q <= trial;
			end
		end

		if (out_load) begin
			rms_value   <= root_q;
			phasor_real <= res_re;
			phasor_imag <= res_im;
		end
	end

	assign out_valid = o_valid_q;

	wrpe_cdiv #(.DIVISOR(WINDOW_SIZE), .W(DIV_W)) u_div_re (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (din_re),
		.quotient (quo_re)
	);

	wrpe_cdiv #(.DIVISOR(WINDOW_SIZE), .W(DIV_W)) u_div_im (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (din_im),
		.quotient (quo_im)
	);

endmodule : wrpe_back

`default_nettype wire

@@ src/window_rms_phasor_estimator.sv @@
// ----------------------------------------------------------------------------
// window_rms_phasor_estimator
// Sliding window of one fundamental period of ADC samples giving RMS and fundamental phasor.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: sample (10 bit unsigned) with in_valid / in_stall. Each
//    item is shifted into a window of WINDOW_SIZE samples (oldest first).
//  - Output channel: rms_value, phasor_real, phasor_imag with out_valid /
//    out_stall; exactly one result item per input item, in order.
//  - A two-entry queue sits in front of the engine, so new items are taken
//    while the engine works or a result waits in the output register.
//  - Sequence: each item passes through the engine in order: it stores the
//    sample, walks the window through the multiply-accumulate pipeline
//    (one entry per cycle from the window memory), sets up, runs the
//    square-root search (a square and a compare step per root bit), which
//    also covers the rounding dividers, and loads the output. The engine
//    takes the next item only once the output of the last one is loaded.
//  - Reset (arst_n low) empties the queue, drops any pending result and
//    marks every window entry as zero.
//  - A stalled output holds its result; the engine then waits in its final
//    state and the queue fills, after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module window_rms_phasor_estimator #(
	parameter int WINDOW_SIZE = wrpe_pkg::DEF_WINDOW_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [wrpe_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic        [wrpe_pkg::RMS_W-1:0]  rms_value,
	output logic signed [wrpe_pkg::PH_W-1:0]   phasor_real,
	output logic signed [wrpe_pkg::PH_W-1:0]   phasor_imag
);
	import wrpe_pkg::*;

	q_head_t  head;
	bk_stat_t bk_stat;
	logic     pop;

	// front: accepts items into the queue
	wrpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.pop      (pop),
		.head     (head)
	);

	// back: window, accumulation, root and dividers, output register
	wrpe_back #(.WINDOW_SIZE(WINDOW_SIZE)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.stat        (bk_stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rms_value   (rms_value),
		.phasor_real (phasor_real),
		.phasor_imag (phasor_imag)
	);

	// engine leaves idle once it takes an item from the queue
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !bk_stat.idle)
		else $error("engine still idle after taking an item");

	// a full queue always offers an item
	a_stall_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head.valid)
		else $error("input stalled with empty queue");

	// a new result only appears out of the final engine state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bk_stat.hold))
		else $error("result raised outside final state");

endmodule : window_rms_phasor_estimator

`default_nettype wire
